// File: hdl/qslerp_pkg.sv
`default_nettype none
package qslerp_pkg;

  // default component width, signed Q2.14
  localparam int COMP_WIDTH = 16;

  // fraction bits of the internal angle and weight formats
  localparam int FRAC_BITS = 28;

  // CORDIC iteration count
  localparam int CORDIC_STEPS = 28;

  // unsigned Q28 magnitudes of dot and sin(theta0), 0 to 1.0 inclusive
  localparam int MAG_W = FRAC_BITS + 1;

  // CORDIC x/y datapath width (gain and sqrt(2) headroom) and angle width
  localparam int XY_W  = 34;
  localparam int ANG_W = 32;

  // s1 weight, saturated to +-2^31
  localparam int S1_W = 33;

  // near_threshold register
  localparam int THR_W = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd16376;

  // blend fraction
  localparam int BLEND_W = 15;
  localparam logic [BLEND_W-1:0] ONE_Q14 = 15'd16384;

endpackage
`default_nettype wire

// File: hdl/qslerp_sqrt.sv
`default_nettype none
// Pipelined floor square root, one result bit per stage.
module qslerp_sqrt #(
  parameter int SIDE_W = 1
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  in_valid,
  input  wire logic [2*qslerp_pkg::FRAC_BITS:0]      rad,
  input  wire logic [SIDE_W-1:0]                     in_side,
  output logic                                       out_valid,
  output logic [qslerp_pkg::MAG_W-1:0]               root,
  output logic [SIDE_W-1:0]                          out_side
);

  localparam int STEPS = qslerp_pkg::MAG_W;
  localparam int RW    = 2 * qslerp_pkg::FRAC_BITS + 2;

  logic [RW-1:0]     rem_q  [STEPS];
  logic [STEPS-1:0]  root_q [STEPS];
  logic              vld_q  [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int B = STEPS - 1 - s;
    logic [RW-1:0]     rem_in;
    logic [STEPS-1:0]  root_in;
    logic              vld_in;
    logic [SIDE_W-1:0] side_in;
    logic [RW-1:0]     test;
    logic              fits;

    if (s == 0) begin : g_first
      assign rem_in  = RW'(rad);
      assign root_in = '0;
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign vld_in  = vld_q[s-1];
      assign side_in = side_q[s-1];
    end

    // (root + 2^B)^2 - root^2
    assign test = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));
    assign fits = rem_in >= test;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= fits ? rem_in - test : rem_in;
        root_q[s] <= fits ? (root_in | (STEPS'(1) << B)) : root_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign out_valid = vld_q[STEPS-1];
  assign root      = root_q[STEPS-1];
  assign out_side  = side_q[STEPS-1];

endmodule
`default_nettype wire

// File: hdl/qslerp_cordic.sv
`default_nettype none
// Pipelined CORDIC, one micro-rotation per stage.
// VECTOR=1: drive y to zero, z collects the angle.
// VECTOR=0: drive z to zero, x/y give cos/sin.
module qslerp_cordic #(
  parameter bit VECTOR = 1'b1,
  parameter int SIDE_W = 1
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  in_valid,
  input  wire logic signed [qslerp_pkg::XY_W-1:0]    x_in,
  input  wire logic signed [qslerp_pkg::XY_W-1:0]    y_in,
  input  wire logic signed [qslerp_pkg::ANG_W-1:0]   z_in,
  input  wire logic [SIDE_W-1:0]                     in_side,
  output logic                                       out_valid,
  output logic signed [qslerp_pkg::XY_W-1:0]         x_out,
  output logic signed [qslerp_pkg::XY_W-1:0]         y_out,
  output logic signed [qslerp_pkg::ANG_W-1:0]        z_out,
  output logic [SIDE_W-1:0]                          out_side
);

  localparam int STEPS = qslerp_pkg::CORDIC_STEPS;
  localparam int XW    = qslerp_pkg::XY_W;
  localparam int AW    = qslerp_pkg::ANG_W;

  // atan(2^-i) in Q28
  localparam logic signed [AW-1:0] ATAN [STEPS] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32,
    32'sd16,        32'sd8,         32'sd4,        32'sd2
  };

  logic signed [XW-1:0] x_q    [STEPS];
  logic signed [XW-1:0] y_q    [STEPS];
  logic signed [AW-1:0] z_q    [STEPS];
  logic                 vld_q  [STEPS];
  logic [SIDE_W-1:0]    side_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [XW-1:0] x_i;
    logic signed [XW-1:0] y_i;
    logic signed [AW-1:0] z_i;
    logic                 vld_i;
    logic [SIDE_W-1:0]    side_i;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic                 ccw;

    if (i == 0) begin : g_first
      assign x_i    = x_in;
      assign y_i    = y_in;
      assign z_i    = z_in;
      assign vld_i  = in_valid;
      assign side_i = in_side;
    end else begin : g_next
      assign x_i    = x_q[i-1];
      assign y_i    = y_q[i-1];
      assign z_i    = z_q[i-1];
      assign vld_i  = vld_q[i-1];
      assign side_i = side_q[i-1];
    end

    assign xs  = x_i >>> i;
    assign ys  = y_i >>> i;
    assign ccw = VECTOR ? y_i[XW-1] : ~z_i[AW-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (ccw) begin
          x_q[i] <= x_i - ys;
          y_q[i] <= y_i + xs;
          z_q[i] <= z_i - ATAN[i];
        end else begin
          x_q[i] <= x_i + ys;
          y_q[i] <= y_i - xs;
          z_q[i] <= z_i + ATAN[i];
        end
        side_q[i] <= side_i;
      end
    end
  end

  assign out_valid = vld_q[STEPS-1];
  assign x_out     = x_q[STEPS-1];
  assign y_out     = y_q[STEPS-1];
  assign z_out     = z_q[STEPS-1];
  assign out_side  = side_q[STEPS-1];

endmodule
`default_nettype wire

// File: hdl/qslerp_div.sv
`default_nettype none
// Pipelined restoring divide, truncating, quotient saturated to +-2^31.
// One overflow-check stage, one stage per quotient bit, one sign stage.
module qslerp_div #(
  parameter int SIDE_W = 1
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  in_valid,
  input  wire logic [qslerp_pkg::XY_W+qslerp_pkg::FRAC_BITS-1:0] num,
  input  wire logic [qslerp_pkg::MAG_W-1:0]          den,
  input  wire logic                                  neg,
  input  wire logic [SIDE_W-1:0]                     in_side,
  output logic                                       out_valid,
  output logic signed [qslerp_pkg::S1_W-1:0]         quot,
  output logic [SIDE_W-1:0]                          out_side
);

  localparam int QB    = qslerp_pkg::S1_W - 1;
  localparam int NUM_W = qslerp_pkg::XY_W + qslerp_pkg::FRAC_BITS;
  localparam int DW    = qslerp_pkg::MAG_W;
  localparam logic [QB-1:0] Q_LIMIT = QB'(1) << (QB - 1);

  // overflow check stage
  logic [NUM_W-1:0]  rem0;
  logic [DW-1:0]     den0;
  logic              neg0;
  logic              ovf0;
  logic              vld0;
  logic [SIDE_W-1:0] side0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0  <= num;
      den0  <= den;
      neg0  <= neg;
      ovf0  <= num >= (NUM_W'(den) << QB);
      side0 <= in_side;
    end
  end

  logic [NUM_W-1:0]  rem_q  [QB];
  logic [DW-1:0]     den_q  [QB];
  logic [QB-1:0]     q_q    [QB];
  logic              neg_q  [QB];
  logic              ovf_q  [QB];
  logic              vld_q  [QB];
  logic [SIDE_W-1:0] side_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int K = QB - 1 - s;
    logic [NUM_W-1:0]  rem_i;
    logic [DW-1:0]     den_i;
    logic [QB-1:0]     q_i;
    logic              neg_i;
    logic              ovf_i;
    logic              vld_i;
    logic [SIDE_W-1:0] side_i;
    logic [NUM_W-1:0]  sub;
    logic              fits;

    if (s == 0) begin : g_first
      assign rem_i  = rem0;
      assign den_i  = den0;
      assign q_i    = '0;
      assign neg_i  = neg0;
      assign ovf_i  = ovf0;
      assign vld_i  = vld0;
      assign side_i = side0;
    end else begin : g_next
      assign rem_i  = rem_q[s-1];
      assign den_i  = den_q[s-1];
      assign q_i    = q_q[s-1];
      assign neg_i  = neg_q[s-1];
      assign ovf_i  = ovf_q[s-1];
      assign vld_i  = vld_q[s-1];
      assign side_i = side_q[s-1];
    end

    assign sub  = NUM_W'(den_i) << K;
    assign fits = rem_i >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= fits ? rem_i - sub : rem_i;
        q_q[s]    <= fits ? (q_i | (QB'(1) << K)) : q_i;
        den_q[s]  <= den_i;
        neg_q[s]  <= neg_i;
        ovf_q[s]  <= ovf_i;
        side_q[s] <= side_i;
      end
    end
  end

  // saturate and apply sign
  logic [QB:0] qmag;

  always_comb begin
    if (ovf_q[QB-1] || (q_q[QB-1] > Q_LIMIT)) begin
      qmag = {1'b0, Q_LIMIT};
    end else begin
      qmag = {1'b0, q_q[QB-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_q[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot     <= neg_q[QB-1] ? -$signed(qmag) : $signed(qmag);
      out_side <= side_q[QB-1];
    end
  end

endmodule
`default_nettype wire

// File: hdl/quaternion_slerp.sv
// Throughput: one word per cycle; the whole pipeline moves as one and
//   holds in place while the output word waits on m_tready.
// Reset (rst, synchronous, active high) empties the pipeline and sets
//   near_threshold to 16376; no other state.
`default_nettype none
module quaternion_slerp #(
  parameter int COMP_WIDTH = qslerp_pkg::COMP_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (COMP_WIDTH each), blend (15)
  input  wire logic [((8*COMP_WIDTH + qslerp_pkg::BLEND_W + 7) / 8) * 8 - 1:0] s_tdata,
  // output stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // out_x, out_y, out_z, out_w (COMP_WIDTH each)
  output logic [((4*COMP_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
  // register port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [0:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int CW     = COMP_WIDTH;
  localparam int IN_W   = 8 * CW + qslerp_pkg::BLEND_W;
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TW = ((4 * CW + 7) / 8) * 8;

  localparam int FB    = qslerp_pkg::FRAC_BITS;
  localparam int MW    = qslerp_pkg::MAG_W;
  localparam int XW    = qslerp_pkg::XY_W;
  localparam int AW    = qslerp_pkg::ANG_W;
  localparam int S1W   = qslerp_pkg::S1_W;
  localparam int TW    = qslerp_pkg::BLEND_W;
  localparam int THW   = qslerp_pkg::THR_W;
  localparam int BW    = CW + 1;            // b after a possible negation
  localparam int A_W   = 4 * CW;
  localparam int B_W   = 4 * BW;
  localparam int DOT_W = (2 * CW + 2 > FB + 3) ? 2 * CW + 2 : FB + 3;
  localparam int HW    = MW - 14;           // high part of d for d*d
  localparam int S0W   = XW + 1;
  localparam int SP_W  = S0W + CW + 1;      // slerp weighted sum
  localparam int LP_W  = CW + 18;           // linear weighted sum
  localparam int NUM_W = XW + FB;

  localparam logic [0:0] ADDR_NEAR_THR = 1'b0;

  localparam logic signed [XW-1:0]  GAIN_INV = 34'sd163008218;
  localparam logic [MW-1:0]         ONE_Q28  = MW'(1) << FB;
  localparam logic signed [SP_W-1:0] SAT_HI  = SP_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SP_W-1:0] SAT_LO  = -SAT_HI - SP_W'(1);

  // ------------------------------------------------------------------
  // Register port: one register, near_threshold, at byte address 0.
  // ------------------------------------------------------------------
  logic [THW-1:0] near_thr;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_thr <= qslerp_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_NEAR_THR)) begin
      near_thr <= pwdata[THW-1:0];
    end
  end

  assign prdata = (paddr == ADDR_NEAR_THR) ? 32'(near_thr) : 32'd0;

  // ------------------------------------------------------------------
  // Flow control: every stage advances together whenever the output
  // register is empty or being drained.
  // ------------------------------------------------------------------
  logic en;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ------------------------------------------------------------------
  // Stage 1: capture, clamp blend to 1.0.
  // ------------------------------------------------------------------
  logic          v1;
  logic [A_W-1:0] a1;
  logic [A_W-1:0] b1;
  logic [TW-1:0]  t1;
  logic [TW-1:0]  blend_in;

  assign blend_in = s_tdata[8*CW +: TW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= s_tdata[0 +: A_W];
      b1 <= s_tdata[A_W +: A_W];
      t1 <= (blend_in > qslerp_pkg::ONE_Q14) ? qslerp_pkg::ONE_Q14 : blend_in;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: four component products of the dot product.
  // ------------------------------------------------------------------
  logic                   v2;
  logic signed [2*CW-1:0] prod2 [4];
  logic [A_W-1:0]         a2;
  logic [A_W-1:0]         b2;
  logic [TW-1:0]          t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        prod2[i] <= $signed(a1[i*CW +: CW]) * $signed(b1[i*CW +: CW]);
      end
      a2 <= a1;
      b2 <= b1;
      t2 <= t1;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: exact dot product in Q28.
  // ------------------------------------------------------------------
  logic                    v3;
  logic signed [DOT_W-1:0] dot3;
  logic [A_W-1:0]          a3;
  logic [A_W-1:0]          b3;
  logic [TW-1:0]           t3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot3 <= DOT_W'(prod2[0]) + DOT_W'(prod2[1]) + DOT_W'(prod2[2]) + DOT_W'(prod2[3]);
      a3   <= a2;
      b3   <= b2;
      t3   <= t2;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: take the short way round (flip b and dot when dot < 0),
  // pick linear mixing above the threshold, limit dot to 1.0.
  // ------------------------------------------------------------------
  logic                    v4;
  logic                    lin4;
  logic [MW-1:0]           d4;
  logic [A_W-1:0]          a4;
  logic [B_W-1:0]          b4;
  logic [TW-1:0]           t4;
  logic                    neg3;
  logic signed [DOT_W-1:0] dabs3;

  assign neg3  = dot3[DOT_W-1];
  assign dabs3 = neg3 ? -dot3 : dot3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        b4[i*BW +: BW] <= neg3 ? -BW'($signed(b3[i*CW +: CW]))
                               :  BW'($signed(b3[i*CW +: CW]));
      end
      lin4 <= dabs3 > $signed(DOT_W'({near_thr, 14'd0}));
      d4   <= (dabs3 > $signed(DOT_W'(ONE_Q28))) ? ONE_Q28 : dabs3[MW-1:0];
      a4   <= a3;
      t4   <= t3;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: d*d as three partial products.
  // ------------------------------------------------------------------
  logic                  v5;
  logic [2*HW-1:0]       hh5;
  logic [HW+13:0]        hl5;
  logic [27:0]           ll5;
  logic                  lin5;
  logic [MW-1:0]         d5;
  logic [A_W-1:0]        a5;
  logic [B_W-1:0]        b5;
  logic [TW-1:0]         t5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hh5  <= d4[MW-1:14] * d4[MW-1:14];
      hl5  <= d4[MW-1:14] * d4[13:0];
      ll5  <= d4[13:0] * d4[13:0];
      lin5 <= lin4;
      d5   <= d4;
      a5   <= a4;
      b5   <= b4;
      t5   <= t4;
    end
  end

  // ------------------------------------------------------------------
  // Stage 6: radicand 1 - d^2 in Q56.
  // ------------------------------------------------------------------
  localparam int RAD_W = 2 * FB + 1;

  logic             v6;
  logic [RAD_W-1:0] rad6;
  logic             lin6;
  logic [MW-1:0]    d6;
  logic [A_W-1:0]   a6;
  logic [B_W-1:0]   b6;
  logic [TW-1:0]    t6;
  logic [RAD_W:0]   dsq5;

  assign dsq5 = ((RAD_W+1)'(hh5) << 28) + ((RAD_W+1)'(hl5) << 15) + (RAD_W+1)'(ll5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad6 <= RAD_W'(((RAD_W+1)'(1) << (2 * FB)) - dsq5);
      lin6 <= lin5;
      d6   <= d5;
      a6   <= a5;
      b6   <= b5;
      t6   <= t5;
    end
  end

  // ------------------------------------------------------------------
  // sin(theta0) = floor(sqrt(1 - d^2)), 29 stages.
  // ------------------------------------------------------------------
  localparam int SQ_SIDE_W = 1 + TW + MW + B_W + A_W;

  logic                 sq_v;
  logic [MW-1:0]        sq_root;
  logic [SQ_SIDE_W-1:0] sq_side;
  logic                 sq_lin;
  logic [TW-1:0]        sq_t;
  logic [MW-1:0]        sq_d;
  logic [B_W-1:0]       sq_b;
  logic [A_W-1:0]       sq_a;

  qslerp_sqrt #(
    .SIDE_W (SQ_SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .rad       (rad6),
    .in_side   ({lin6, t6, d6, b6, a6}),
    .out_valid (sq_v),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  assign {sq_lin, sq_t, sq_d, sq_b, sq_a} = sq_side;

  // ------------------------------------------------------------------
  // theta0 = atan2(sin0, d), 28 stages. A zero sine forces linear mix.
  // ------------------------------------------------------------------
  localparam int CS_W = 1 + TW + MW + MW + B_W + A_W;

  logic                 vc_v;
  logic signed [AW-1:0] theta0;
  logic [CS_W-1:0]      vc_side;
  logic signed [XW-1:0] vc_x;
  logic signed [XW-1:0] vc_y;

  qslerp_cordic #(
    .VECTOR (1'b1),
    .SIDE_W (CS_W)
  ) u_vector (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_v),
    .x_in      ($signed(XW'(sq_d))),
    .y_in      ($signed(XW'(sq_root))),
    .z_in      ('0),
    .in_side   ({sq_lin || (sq_root == '0), sq_t, sq_d, sq_root, sq_b, sq_a}),
    .out_valid (vc_v),
    .x_out     (vc_x),
    .y_out     (vc_y),
    .z_out     (theta0),
    .out_side  (vc_side)
  );

  // ------------------------------------------------------------------
  // Stages 8 and 9: theta = round(theta0 * t).
  // ------------------------------------------------------------------
  logic                       v8;
  logic signed [AW+TW:0]      tp8;
  logic [CS_W-1:0]            side8;
  logic                       v9;
  logic signed [AW-1:0]       theta9;
  logic [CS_W-1:0]            side9;
  logic signed [AW+TW:0]      tr8;
  logic [TW-1:0]              vc_t;

  assign vc_t = vc_side[CS_W-2 -: TW];
  assign tr8  = (tp8 + (AW+TW+1)'(1 << 13)) >>> 14;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else if (en) begin
      v8 <= vc_v;
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tp8    <= theta0 * $signed({1'b0, vc_t});
      side8  <= vc_side;
      theta9 <= tr8[AW-1:0];
      side9  <= side8;
    end
  end

  // ------------------------------------------------------------------
  // cos(theta), sin(theta), 28 stages.
  // ------------------------------------------------------------------
  logic                 rc_v;
  logic signed [XW-1:0] ct;
  logic signed [XW-1:0] st;
  logic signed [AW-1:0] rc_z;
  logic [CS_W-1:0]      rc_side;
  logic                 rc_lin;
  logic [TW-1:0]        rc_t;
  logic [MW-1:0]        rc_d;
  logic [MW-1:0]        rc_sin0;
  logic [B_W-1:0]       rc_b;
  logic [A_W-1:0]       rc_a;

  qslerp_cordic #(
    .VECTOR (1'b0),
    .SIDE_W (CS_W)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v9),
    .x_in      (GAIN_INV),
    .y_in      ('0),
    .z_in      (theta9),
    .in_side   (side9),
    .out_valid (rc_v),
    .x_out     (ct),
    .y_out     (st),
    .z_out     (rc_z),
    .out_side  (rc_side)
  );

  assign {rc_lin, rc_t, rc_d, rc_sin0, rc_b, rc_a} = rc_side;

  // ------------------------------------------------------------------
  // Stage 10: sign and magnitude of sin(theta) for the divider.
  // ------------------------------------------------------------------
  localparam int DV_SIDE_W = 1 + TW + MW + XW + B_W + A_W;

  logic             v10;
  logic             neg10;
  logic [XW-1:0]    mag10;
  logic [MW-1:0]    sin10;
  logic [DV_SIDE_W-1:0] side10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= rc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg10  <= st[XW-1];
      mag10  <= st[XW-1] ? XW'(-st) : XW'(st);
      sin10  <= rc_sin0;
      side10 <= {rc_lin, rc_t, rc_d, ct, rc_b, rc_a};
    end
  end

  // ------------------------------------------------------------------
  // s1 = sin(theta) / sin(theta0) in Q28, 34 stages.
  // ------------------------------------------------------------------
  logic                  dv_v;
  logic signed [S1W-1:0] s1;
  logic [DV_SIDE_W-1:0]  dv_side;
  logic                  dv_lin;
  logic [TW-1:0]         dv_t;
  logic [MW-1:0]         dv_d;
  logic signed [XW-1:0]  dv_ct;
  logic [B_W-1:0]        dv_b;
  logic [A_W-1:0]        dv_a;

  qslerp_div #(
    .SIDE_W (DV_SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v10),
    .num       ({mag10, {FB{1'b0}}}),
    .den       (sin10),
    .neg       (neg10),
    .in_side   (side10),
    .out_valid (dv_v),
    .quot      (s1),
    .out_side  (dv_side)
  );

  assign {dv_lin, dv_t, dv_d, dv_ct, dv_b, dv_a} = dv_side;

  // ------------------------------------------------------------------
  // Stages 11 and 12: s0 = cos(theta) - round(d * s1).
  // ------------------------------------------------------------------
  localparam int DS_W = MW + 1 + S1W;

  logic                  v11;
  logic signed [DS_W-1:0] ds11;
  logic signed [S1W-1:0] s1_11;
  logic signed [XW-1:0]  ct11;
  logic                  lin11;
  logic [TW-1:0]         t11;
  logic [B_W-1:0]        b11;
  logic [A_W-1:0]        a11;

  logic                  v12;
  logic signed [S0W-1:0] s0_12;
  logic signed [S1W-1:0] s1_12;
  logic                  lin12;
  logic [TW-1:0]         t12;
  logic [B_W-1:0]        b12;
  logic [A_W-1:0]        a12;
  logic signed [DS_W-1:0] dsr11;

  assign dsr11 = (ds11 + DS_W'(64'sd1 <<< (FB - 1))) >>> FB;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
      v12 <= 1'b0;
    end else if (en) begin
      v11 <= dv_v;
      v12 <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds11  <= $signed({1'b0, dv_d}) * s1;
      s1_11 <= s1;
      ct11  <= dv_ct;
      lin11 <= dv_lin;
      t11   <= dv_t;
      b11   <= dv_b;
      a11   <= dv_a;

      s0_12 <= S0W'(ct11) - dsr11[S0W-1:0];
      s1_12 <= s1_11;
      lin12 <= lin11;
      t12   <= t11;
      b12   <= b11;
      a12   <= a11;
    end
  end

  // ------------------------------------------------------------------
  // Stage 13: weight products for both the slerp and the linear mix.
  // ------------------------------------------------------------------
  logic                     v13;
  logic                     lin13;
  logic signed [S0W+CW-1:0] pa13 [4];
  logic signed [S1W+BW-1:0] pb13 [4];
  logic signed [CW+TW:0]    la13 [4];
  logic signed [BW+TW:0]    lb13 [4];
  logic [TW-1:0]            om12;

  assign om12 = qslerp_pkg::ONE_Q14 - t12;

  always_ff @(posedge clk) begin
    if (rst) begin
      v13 <= 1'b0;
    end else if (en) begin
      v13 <= v12;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        pa13[i] <= s0_12 * $signed(a12[i*CW +: CW]);
        pb13[i] <= s1_12 * $signed(b12[i*BW +: BW]);
        la13[i] <= $signed(a12[i*CW +: CW]) * $signed({1'b0, om12});
        lb13[i] <= $signed(b12[i*BW +: BW]) * $signed({1'b0, t12});
      end
      lin13 <= lin12;
    end
  end

  // ------------------------------------------------------------------
  // Stage 14: sum, round, select, saturate into the output register.
  // ------------------------------------------------------------------
  logic [A_W-1:0] out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v13;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_out
    logic signed [SP_W-1:0] ssum;
    logic signed [LP_W-1:0] lsum;
    logic signed [SP_W-1:0] pick;

    assign ssum = (SP_W'(pa13[i]) + SP_W'(pb13[i]) + SP_W'(64'sd1 <<< (FB - 1))) >>> FB;
    assign lsum = (LP_W'(la13[i]) + LP_W'(lb13[i]) + LP_W'(1 << 13)) >>> 14;
    assign pick = lin13 ? SP_W'(lsum) : ssum;

    always_ff @(posedge clk) begin
      if (en) begin
        if (pick > SAT_HI) begin
          out_q[i*CW +: CW] <= SAT_HI[CW-1:0];
        end else if (pick < SAT_LO) begin
          out_q[i*CW +: CW] <= SAT_LO[CW-1:0];
        end else begin
          out_q[i*CW +: CW] <= pick[CW-1:0];
        end
      end
    end
  end

  assign m_tdata = OUT_TW'(out_q);

endmodule
`default_nettype wire
